// ----- hdl/c3x3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_pkg
// shared types and constants for the 3x3 eight-filter convolution stream
// ----------------------------------------------------------------------------
package c3x3_pkg;
  localparam int FILTERS  = 8;
  localparam int TAPS     = 9;
  localparam int WEIGHTS  = 72;
  localparam int SUM_W    = 36;
  localparam int PIX_W    = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL  = 1'b0,
    KIND_WEIGHT = 1'b1
  } item_kind_t;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [FILTERS-1:0] sums_t;
endpackage

// ----- hdl/c3x3_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3 channel interfaces
// valid/ready channels for input items, results and register writes
// ----------------------------------------------------------------------------
interface c3x3_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] value;
  logic [6:0]         weight_index;
  modport source (output valid, kind, value, weight_index, input ready);
  modport sink   (input valid, kind, value, weight_index, output ready);
endinterface

interface c3x3_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         out_row;
  logic [5:0]         out_col;
  logic               frame_last;
  logic signed [35:0] sum_f0, sum_f1, sum_f2, sum_f3, sum_f4, sum_f5, sum_f6, sum_f7;
  modport source (output valid, out_row, out_col, frame_last, sum_f0, sum_f1, sum_f2,
                  sum_f3, sum_f4, sum_f5, sum_f6, sum_f7, input ready);
  modport sink   (input valid, out_row, out_col, frame_last, sum_f0, sum_f1, sum_f2,
                  sum_f3, sum_f4, sum_f5, sum_f6, sum_f7, output ready);
endinterface

interface c3x3_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/conv3x3_eight_filter_stream.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_eight_filter_stream
// valid 3x3 convolution of a pixel stream with eight filters
// ----------------------------------------------------------------------------
// Pixels in raster order and weight writes share the input channel; items
// enter one per cycle unless the output stalls. Two line memories with
// registered reads hold the two rows above; a pixel reads its column in
// stage 1, shifts the window and writes back in stage 2, and the 72
// products are formed in stage 3 and summed in stage 4 before the output
// register. A back-to-back same-column access cannot occur at widths of
// three or more, so no forwarding is needed beyond the line stores' own
// write-after-read ordering. A weight write reaching the multipliers while
// pixels are in flight takes effect in item order.
module conv3x3_eight_filter_stream #(
  parameter int MAX_WIDTH = 64
) (
  input  logic clk,
  input  logic rst_n,
  c3x3_in_if.sink    in_ch,
  c3x3_out_if.source out_ch,
  c3x3_cfg_if.sink   cfg_ch
);
  import c3x3_pkg::*;
  localparam int CW = $clog2(MAX_WIDTH);

  logic [6:0] width_r, height_r;
  logic [6:0] w_eff, h_eff;
  logic [CW:0] w_last;
  logic [6:0] h_last;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 7'd28;
      height_r <= 7'd28;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_WIDTH:  width_r  <= cfg_ch.data;
        REG_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_r < 7'd3) ? 7'd3 : width_r;
    h_eff = (height_r < 7'd3) ? 7'd3 : ((height_r > 7'd64) ? 7'd64 : height_r);
    if ({{(CW+1){1'b0}}, w_eff} > (CW+8)'(MAX_WIDTH))
      w_last = (CW+1)'(MAX_WIDTH - 1);
    else
      w_last = (CW+1)'(w_eff - 7'd1);
    h_last = h_eff - 7'd1;
  end

  // pipeline advance: all stages move when the output register is free
  logic adv;
  logic s4_v_r;
  logic o_v_r;
  assign adv = !o_v_r || out_ch.ready;
  assign in_ch.ready = adv;
  logic take;
  assign take = in_ch.valid && adv;

  // weight writes pass through a holding register before the store, so a pixel
  // already past stage 1 still multiplies with the old coefficients
  logic                    wq_v_r;
  logic [6:0]              wq_idx_r;
  logic signed [PIX_W-1:0] wq_val_r;
  always_ff @(posedge clk) begin
    if (!rst_n) wq_v_r <= 1'b0;
    else if (adv) wq_v_r <= take && in_ch.kind == KIND_WEIGHT &&
                            in_ch.weight_index < 7'(WEIGHTS);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      wq_idx_r <= in_ch.weight_index;
      wq_val_r <= in_ch.value;
    end
  end

  // weight store
  logic signed [PIX_W-1:0] wts_r [WEIGHTS];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WEIGHTS; i++) wts_r[i] <= '0;
    end else if (adv && wq_v_r) begin
      wts_r[wq_idx_r] <= wq_val_r;
    end
  end

  // position counters
  logic [CW:0] col_r;
  logic [5:0]  row_r;
  logic        is_pix;
  assign is_pix = take && in_ch.kind == KIND_PIXEL;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (is_pix) begin
      if (col_r >= w_last) begin
        col_r <= '0;
        if ({1'b0, row_r} >= h_last) row_r <= '0;
        else row_r <= row_r + 6'd1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // stage 1: line memory read issued
  logic              s1_v_r, s1_emit_r, s1_last_r;
  logic [CW-1:0]     s1_col_r;
  logic [5:0]        s1_orow_r, s1_ocol_r;
  logic signed [15:0] s1_pix_r;
  logic signed [15:0] lma [MAX_WIDTH];
  logic signed [15:0] lmb [MAX_WIDTH];
  logic signed [15:0] rda_r, rdb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= is_pix;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col_r  <= col_r[CW-1:0];
      s1_pix_r  <= in_ch.value;
      s1_emit_r <= (row_r >= 6'd2) && (col_r >= (CW+1)'(2));
      s1_last_r <= ({1'b0, row_r} >= h_last) && (col_r >= w_last);
      s1_orow_r <= row_r - 6'd2;
      s1_ocol_r <= 6'(col_r - (CW+1)'(2));
      rda_r <= lma[col_r[CW-1:0]];
      rdb_r <= lmb[col_r[CW-1:0]];
    end
  end

  // stage 2: write back and shift window
  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      lma[s1_col_r] <= s1_pix_r;
      lmb[s1_col_r] <= rda_r;
    end
  end

  logic signed [15:0] win_r [TAPS];
  logic s2_v_r, s2_last_r;
  logic [5:0] s2_orow_r, s2_ocol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) win_r[i] <= '0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_emit_r;
      if (s1_v_r) begin
        for (int k = 0; k < 3; k++) begin
          win_r[k*3]   <= win_r[k*3+1];
          win_r[k*3+1] <= win_r[k*3+2];
        end
        win_r[2] <= rdb_r;
        win_r[5] <= rda_r;
        win_r[8] <= s1_pix_r;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last_r <= s1_last_r;
      s2_orow_r <= s1_orow_r;
      s2_ocol_r <= s1_ocol_r;
    end
  end

  // stage 3: products
  logic signed [31:0] prod_r [WEIGHTS];
  logic s3_v_r, s3_last_r;
  logic [5:0] s3_orow_r, s3_ocol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int f = 0; f < FILTERS; f++)
        for (int t = 0; t < TAPS; t++)
          prod_r[f*TAPS+t] <= win_r[t] * wts_r[f*TAPS+t];
      s3_last_r <= s2_last_r;
      s3_orow_r <= s2_orow_r;
      s3_ocol_r <= s2_ocol_r;
    end
  end

  // stage 4: sums
  sums_t s4_sum_r;
  logic s4_last_r;
  logic [5:0] s4_orow_r, s4_ocol_r;
  sums_t sum_c;
  always_comb begin
    for (int f = 0; f < FILTERS; f++) begin
      sum_c[f] = '0;
      for (int t = 0; t < TAPS; t++)
        sum_c[f] = sum_c[f] + SUM_W'(prod_r[f*TAPS+t]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sum_r  <= sum_c;
      s4_last_r <= s3_last_r;
      s4_orow_r <= s3_orow_r;
      s4_ocol_r <= s3_ocol_r;
    end
  end

  // output register
  sums_t o_sum_r;
  logic o_last_r;
  logic [5:0] o_row_r, o_col_r;
  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (adv) o_v_r <= s4_v_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      o_sum_r  <= s4_sum_r;
      o_last_r <= s4_last_r;
      o_row_r  <= s4_orow_r;
      o_col_r  <= s4_ocol_r;
    end
  end

  assign out_ch.valid      = o_v_r;
  assign out_ch.out_row    = o_row_r;
  assign out_ch.out_col    = o_col_r;
  assign out_ch.frame_last = o_last_r;
  assign out_ch.sum_f0 = o_sum_r[0];
  assign out_ch.sum_f1 = o_sum_r[1];
  assign out_ch.sum_f2 = o_sum_r[2];
  assign out_ch.sum_f3 = o_sum_r[3];
  assign out_ch.sum_f4 = o_sum_r[4];
  assign out_ch.sum_f5 = o_sum_r[5];
  assign out_ch.sum_f6 = o_sum_r[6];
  assign out_ch.sum_f7 = o_sum_r[7];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && !out_ch.ready |=> o_v_r && $stable(o_row_r) && $stable(o_col_r))
    else $error("result dropped while stalled");
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= (CW+1)'(MAX_WIDTH - 1))
    else $error("column past line memory");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s4_v_r) && $stable(s1_v_r))
    else $error("pipeline moved during stall");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    o_v_r && o_last_r |-> o_row_r >= 6'(h_last - 7'd2))
    else $error("frame end at wrong row");
endmodule

// ----- bench/c3x3_test_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c3x3_test_pkg
// stimulus row type shared by the convolution stream bench
// ----------------------------------------------------------------------------
package c3x3_test_pkg;
  import c3x3_pkg::*;

  typedef struct {
    item_kind_t         kind;
    logic signed [15:0] value;
    logic [6:0]         widx;
  } conv_item_t;

  typedef struct {
    logic [5:0] row;
    logic [5:0] col;
    logic       last;
    sums_t      sums;
  } conv_result_t;
endpackage

// ----- bench/conv3x3_eight_filter_stream_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_eight_filter_stream_test
// self-checking bench for the 3x3 eight-filter convolution stream
// ----------------------------------------------------------------------------
// Weights and pixels go through the input channel; a local model of the line
// stores, window and weights predicts every result, which is compared field by
// field. Image sizes change between phases, including the extremes and values
// outside the allowed range. Both channels idle at random, with a long output
// stall and a pause until the pipeline drains.
module conv3x3_eight_filter_stream_test;
  import c3x3_pkg::*;
  import c3x3_test_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  c3x3_in_if  in_ch ();
  c3x3_out_if out_ch ();
  c3x3_cfg_if cfg_ch ();

  conv3x3_eight_filter_stream dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // model state
  logic [6:0]         img_w, img_h;
  logic signed [15:0] row_prev [64];
  logic signed [15:0] row_prev2 [64];
  logic signed [15:0] win [9];
  logic signed [15:0] coef [WEIGHTS];
  int unsigned        cur_col, cur_row;

  conv_result_t expected_q[$];
  int  errors = 0;
  bit  no_idle = 1'b0;
  bit  hold_out = 1'b0;

  function automatic int unsigned clamp_size(logic [6:0] v);
    if (v < 3) return 3;
    if (v > 64) return 64;
    return v;
  endfunction

  task automatic model_reset();
    img_w = 7'd28;
    img_h = 7'd28;
    foreach (row_prev[i]) begin
      row_prev[i] = '0;
      row_prev2[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    foreach (coef[i]) coef[i] = '0;
    cur_col = 0;
    cur_row = 0;
  endtask

  // advances the model by one item, queues a result where a window completes
  task automatic predict_window(conv_item_t it);
    int unsigned  w, h, c;
    conv_result_t r;
    logic signed [35:0] acc;
    w = clamp_size(img_w);
    h = clamp_size(img_h);
    if (it.kind == KIND_WEIGHT) begin
      if (it.widx < WEIGHTS) coef[it.widx] = it.value;
      return;
    end
    c = cur_col % 64;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = row_prev2[c];
    win[5] = row_prev[c];
    win[8] = it.value;
    row_prev2[c] = row_prev[c];
    row_prev[c] = it.value;
    if (cur_row >= 2 && cur_col >= 2) begin
      r.row = 6'(cur_row - 2);
      r.col = 6'(cur_col - 2);
      r.last = (cur_row >= h - 1 && cur_col >= w - 1);
      for (int f = 0; f < FILTERS; f++) begin
        acc = '0;
        for (int t = 0; t < TAPS; t++) acc += 36'(win[t] * coef[f*TAPS+t]);
        r.sums[f] = acc;
      end
      expected_q = {expected_q, r};
    end
    if (cur_col >= w - 1) begin
      cur_col = 0;
      cur_row = (cur_row >= h - 1) ? 0 : cur_row + 1;
    end else begin
      cur_col++;
    end
  endtask

  task automatic send_item(conv_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.kind <= it.kind;
    in_ch.value <= it.value;
    in_ch.weight_index <= it.widx;
    do @(posedge clk); while (!in_ch.ready);
    predict_window(it);
    if (!no_idle && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // pixels that make no result may still be in flight
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [6:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_WIDTH) img_w = d;
    else img_h = d;
    @(posedge clk);
  endtask

  function automatic conv_item_t pix(logic signed [15:0] v);
    return '{KIND_PIXEL, v, 7'($urandom_range(127))};
  endfunction

  function automatic conv_item_t wgt(int i, logic signed [15:0] v);
    return '{KIND_WEIGHT, v, 7'(i)};
  endfunction

  task automatic send_image(int unsigned w, int unsigned h, bit extreme);
    for (int i = 0; i < w * h; i++) begin
      if (extreme) send_item(pix(($urandom_range(1)) ? 16'sh7fff : 16'sh8000));
      else send_item(pix(16'($urandom)));
    end
  endtask

  task automatic load_weights(bit extreme);
    for (int i = 0; i < WEIGHTS; i++)
      send_item(wgt(i, extreme ? (($urandom_range(1)) ? 16'sh7fff : 16'sh8000)
                               : 16'($urandom)));
  endtask

  // receiver
  always @(posedge clk) begin
    if (!rst_n || hold_out) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    conv_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: row %0d col %0d",
               out_ch.out_row, out_ch.out_col);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_ch.out_row !== e.row) begin
          $error("out_row expected %0d actual %0d", e.row, out_ch.out_row); errors++;
        end
        if (out_ch.out_col !== e.col) begin
          $error("out_col expected %0d actual %0d", e.col, out_ch.out_col); errors++;
        end
        if (out_ch.frame_last !== e.last) begin
          $error("frame_last expected %0d actual %0d", e.last, out_ch.frame_last);
          errors++;
        end
        if (out_ch.sum_f0 !== e.sums[0]) begin
          $error("sum_f0 expected %0d actual %0d", e.sums[0], out_ch.sum_f0); errors++;
        end
        if (out_ch.sum_f1 !== e.sums[1]) begin
          $error("sum_f1 expected %0d actual %0d", e.sums[1], out_ch.sum_f1); errors++;
        end
        if (out_ch.sum_f2 !== e.sums[2]) begin
          $error("sum_f2 expected %0d actual %0d", e.sums[2], out_ch.sum_f2); errors++;
        end
        if (out_ch.sum_f3 !== e.sums[3]) begin
          $error("sum_f3 expected %0d actual %0d", e.sums[3], out_ch.sum_f3); errors++;
        end
        if (out_ch.sum_f4 !== e.sums[4]) begin
          $error("sum_f4 expected %0d actual %0d", e.sums[4], out_ch.sum_f4); errors++;
        end
        if (out_ch.sum_f5 !== e.sums[5]) begin
          $error("sum_f5 expected %0d actual %0d", e.sums[5], out_ch.sum_f5); errors++;
        end
        if (out_ch.sum_f6 !== e.sums[6]) begin
          $error("sum_f6 expected %0d actual %0d", e.sums[6], out_ch.sum_f6); errors++;
        end
        if (out_ch.sum_f7 !== e.sums[7]) begin
          $error("sum_f7 expected %0d actual %0d", e.sums[7], out_ch.sum_f7); errors++;
        end
      end
    end
  end

  // directed table: small 3x3 images with hand-readable sums
  conv_item_t   directed [$];
  conv_result_t typed_q [$];

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_PIXEL;
    in_ch.value = '0;
    in_ch.weight_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_WIDTH;
    cfg_ch.data = '0;
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_WIDTH, 7'd3);
    write_reg(REG_HEIGHT, 7'd3);
    // all weights zero after reset: every sum zero
    for (int i = 0; i < 9; i++) directed = {directed, pix(16'sh7fff)};
    // center tap of filter 0 at max, filter 7 corner at min; index above 71 ignored
    directed = {directed, wgt(4, 16'sh7fff)};
    directed = {directed, wgt(71, 16'sh8000)};
    directed = {directed, wgt(127, 16'sh7fff)};
    for (int i = 0; i < 9; i++) directed = {directed, pix(16'sh8000)};
    foreach (directed[i]) begin
      if (i == 9) begin
        wait (expected_q.size() != 0);
        if (expected_q[expected_q.size()-1].sums !== '0 ||
            expected_q[expected_q.size()-1].last !== 1'b1) begin
          $error("sums expected 0 after reset, model disagrees"); errors++;
        end
      end
      send_item(directed[i]);
    end
    // (-32768)*(32767) on filter 0, (-32768)*(-32768) on filter 7
    if (expected_q.size() != 0 &&
        (expected_q[$].sums[0] !== 36'sh0 - 36'sd1073709056 ||
         expected_q[$].sums[7] !== 36'sd1073741824)) begin
      $error("sum_f0 expected %0d actual %0d", -1073709056, expected_q[$].sums[0]);
      errors++;
    end
    drain();

    // extreme weights and pixels at the largest width and smallest height, set by out-of-range values
    write_reg(REG_WIDTH, 7'd127);
    write_reg(REG_HEIGHT, 7'd0);
    load_weights(1'b1);
    send_image(64, 3, 1'b1);
    drain();

    // receiver stalls long while the sender keeps offering
    write_reg(REG_WIDTH, 7'd5);
    write_reg(REG_HEIGHT, 7'd4);
    fork
      begin
        hold_out = 1'b1;
        repeat (200) @(posedge clk);
        hold_out = 1'b0;
      end
      send_image(5, 4, 1'b0);
    join
    drain();

    // random phases, one with no idling
    for (int p = 0; p < 2; p++) begin
      logic [6:0] w, h;
      w = 7'($urandom_range(6, 0));
      h = 7'($urandom_range(6, 3));
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      no_idle = (p == 1);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(9) == 0) send_item(wgt($urandom_range(127), 16'($urandom)));
        else send_item(pix(16'($urandom)));
      end
      no_idle = 1'b0;
      drain();
    end

    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
hdl/c3x3_pkg.sv
hdl/c3x3_if.sv
hdl/conv3x3_eight_filter_stream.sv
bench/c3x3_test_pkg.sv
bench/conv3x3_eight_filter_stream_test.sv
